/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is active
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is active
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wemg_pkg.sv */
// Types and constants shared by the maze generator modules
package wemg_pkg;

    localparam int DIM_W  = 7;
    localparam int DRAW_W = 16;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int CAND_W = 13;
    localparam int FUNC_W = 2;

    localparam logic [KIND_W-1:0] KIND_PATH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WALL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GOAL  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_GEN  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IDLE = 2'd3;

    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd11;
    localparam logic [DIM_W-1:0] DIM_MIN   = 7'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PICK,
        PH_EXTEND,
        PH_DONE
    } t_phase;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_BADSIZE,
        OP_FILL_INIT,
        OP_FILL,
        OP_DIV_INIT,
        OP_DIV,
        OP_PRD1,
        OP_PRD2,
        OP_PRD3,
        OP_PCHK,
        OP_FSTART,
        OP_FGOAL,
        OP_XNEAR,
        OP_XFAR,
        OP_XDEC,
        OP_XFARW,
        OP_CM,
        OP_CME,
        OP_RDCELL,
        OP_RDCAP,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_DIV,
        ST_PRD1,
        ST_PRD2,
        ST_PRD3,
        ST_PCHK,
        ST_FCHK,
        ST_FSTART,
        ST_FGOAL,
        ST_XFAR,
        ST_XDEC,
        ST_XFARW,
        ST_CM,
        ST_CME,
        ST_RDCAP,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        t_phase            phase;
        logic              size_ok;
        logic              rd_ok;
        logic              dir_open;
        logic              div_last;
        logic              scan_last;
        logic              p_wall;
        logic              len_zero;
        logic              x_both;
        logic              x_close;
    } t_dp_stat;

endpackage

/* rtl/wall_extension_maze_generator.sv */
// Wall-extension maze generator top level: sequencer plus grid datapath
// A read captures one cell; a draw in pick runs a bit-serial modulo, swap-removes a start
//   candidate and checks it, placing start and goal once the list is empty; a draw in extend
//   reads the near and far cells, marks them and may commit the wall, one grid cell swept per cycle.
// Start fills the grid the same way. One item in flight: the next transfer waits for the result to load.
// Reset (synchronous, active low): idle, configured size 11 x 11, grid and list unwritten, result not reset.
`include "assert_macros.svh"
module wall_extension_maze_generator import wemg_pkg::*; #(
    parameter int MAX_DIM   = 128,
    parameter int DRAW_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    // command channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [DRAW_W-1:0] i_draw,
    input  logic [DIM_W-1:0]  i_cell_row,
    input  logic [DIM_W-1:0]  i_cell_col,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [KIND_W-1:0] o_cell_kind,
    output logic [CAND_W-1:0] o_candidates_left
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: one state per step of the current item, at most one op per cycle
    wemg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Datapath: grid RAM, start-list RAM (swap-remove), modulo divider,
    // walk registers, fill and commit sweep counters, result register
    wemg_dp #(
        .MAX_DIM  (MAX_DIM),
        .DRAW_BITS(DRAW_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_draw           (i_draw),
        .i_cell_row       (i_cell_row),
        .i_cell_col       (i_cell_col),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_cell_kind      (o_cell_kind),
        .o_candidates_left(o_candidates_left)
    );

    // A finished maze has used up every start candidate
    `ASSERT_IMP(a_done_empty, o_out_valid && o_status == STAT_DONE, o_candidates_left == '0, "done with candidates left")
    // An accepted transfer is decoded next, so the input is closed in the following cycle
    `ASSERT_NXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "input reopened right after a transfer")
    // Pick checks only happen while picking
    `ASSERT_IMP(a_pick_phase, cmd.op == OP_PCHK, stat.phase == PH_PICK, "pick check outside pick phase")
endmodule

/* rtl/wemg_ram.sv */
// Generic single-write, single-read RAM with registered read data
module wemg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/wemg_ctrl.sv */
// Sequencer for the maze generator: one item at a time, issues datapath ops
module wemg_ctrl import wemg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);
    t_state r_state, n_state;
    logic   r_out_valid;
    t_op    op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        op         = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    op      = OP_ACCEPT;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_FIN;
                case (i_stat.func)
                    FUNC_START: begin
                        if (i_stat.size_ok) begin
                            op      = OP_FILL_INIT;
                            n_state = ST_FILL;
                        end else begin
                            op = OP_BADSIZE;
                        end
                    end
                    FUNC_DRAW: begin
                        if (i_stat.phase == PH_PICK) begin
                            op      = OP_DIV_INIT;
                            n_state = ST_DIV;
                        end else if (i_stat.phase == PH_EXTEND && i_stat.dir_open) begin
                            op      = OP_XNEAR;
                            n_state = ST_XFAR;
                        end
                    end
                    FUNC_READ: begin
                        if (i_stat.rd_ok) begin
                            op      = OP_RDCELL;
                            n_state = ST_RDCAP;
                        end
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_FILL: begin
                op = OP_FILL;
                if (i_stat.scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = ST_PRD1;
                end
            end
            ST_PRD1: begin
                op      = OP_PRD1;
                n_state = ST_PRD2;
            end
            ST_PRD2: begin
                op      = OP_PRD2;
                n_state = ST_PRD3;
            end
            ST_PRD3: begin
                op      = OP_PRD3;
                n_state = ST_PCHK;
            end
            ST_PCHK: begin
                op      = OP_PCHK;
                n_state = i_stat.p_wall ? ST_FCHK : ST_FIN;
            end
            ST_FCHK: begin
                n_state = i_stat.len_zero ? ST_FSTART : ST_FIN;
            end
            ST_FSTART: begin
                op      = OP_FSTART;
                n_state = ST_FGOAL;
            end
            ST_FGOAL: begin
                op      = OP_FGOAL;
                n_state = ST_FIN;
            end
            ST_XFAR: begin
                op      = OP_XFAR;
                n_state = ST_XDEC;
            end
            ST_XDEC: begin
                op = OP_XDEC;
                if (i_stat.x_both) begin
                    n_state = ST_XFARW;
                end else if (i_stat.x_close) begin
                    n_state = ST_CM;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_XFARW: begin
                op      = OP_XFARW;
                n_state = ST_FIN;
            end
            ST_CM: begin
                op = OP_CM;
                if (i_stat.scan_last) begin
                    n_state = ST_CME;
                end
            end
            ST_CME: begin
                op      = OP_CME;
                n_state = ST_FCHK;
            end
            ST_RDCAP: begin
                op      = OP_RDCAP;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    op      = OP_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd.op    = op;
    assign o_out_valid = r_out_valid;
endmodule

/* rtl/wemg_dp.sv */
// Maze datapath: grid and start-list RAMs, divider, walk and sweep registers
module wemg_dp import wemg_pkg::*; #(
    parameter int MAX_DIM   = 128,
    parameter int DRAW_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [DRAW_W-1:0] i_draw,
    input  logic [DIM_W-1:0]  i_cell_row,
    input  logic [DIM_W-1:0]  i_cell_col,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic [STAT_W-1:0] o_status,
    output logic [KIND_W-1:0] o_cell_kind,
    output logic [CAND_W-1:0] o_candidates_left
);
    localparam int CW   = $clog2(MAX_DIM);
    localparam int AW   = 2 * CW;
    localparam int SW   = CW + 2;
    localparam int XW   = (SW > DIM_W + 1) ? SW : DIM_W + 1;
    localparam int HALF = MAX_DIM / 2;
    localparam int LD   = HALF * HALF;
    localparam int LAW  = $clog2(LD);
    localparam int LW   = $clog2(LD + 1);
    localparam int EW   = 2 * CW;
    localparam int DW   = (DRAW_BITS < DRAW_W) ? DRAW_BITS : DRAW_W;
    localparam int CNW  = $clog2(DW + 1);

    // Configuration, latched size, phase, list length and walk state
    logic [DIM_W-1:0] r_cfg_rows, r_cfg_cols, r_rows, r_cols;
    logic             r_size_err;
    t_phase           r_phase;
    logic [LW-1:0]    r_len;
    logic [CW-1:0]    r_walk_r, r_walk_c;
    logic [3:0]       r_open;

    // Latched item
    logic [FUNC_W-1:0] r_func;
    logic [DW-1:0]     r_draw;
    logic [DIM_W-1:0]  r_rr, r_cc;
    logic [KIND_W-1:0] r_kind;

    // Scan counters, divider, pick and walk temporaries
    logic [CW-1:0]     r_fr, r_fc;
    logic [LW-1:0]     r_rem;
    logic [DW-1:0]     r_dsh;
    logic [CNW-1:0]    r_cnt;
    logic [EW-1:0]     r_p;
    logic [1:0]        r_dir;
    logic [SW-1:0]     r_near_r, r_near_c, r_far_r, r_far_c;
    logic              r_n_in, r_f_in;
    logic [KIND_W-1:0] r_nk;
    logic              r_cm_v;
    logic [AW-1:0]     r_cm_addr;

    // Output register
    logic [STAT_W-1:0] r_o_status;
    logic [KIND_W-1:0] r_o_kind;
    logic [CAND_W-1:0] r_o_cand;

    // RAM ports
    logic              g_we, l_we;
    logic [AW-1:0]     g_waddr, g_raddr;
    logic [KIND_W-1:0] g_wdata, g_rdata;
    logic [LAW-1:0]    l_waddr, l_raddr;
    logic [EW-1:0]     l_wdata, l_rdata;

    logic [XW-1:0]     rows_x, cols_x, fr_x, fc_x;
    logic              border, even_int, scan_last;
    logic [LW:0]       trial;
    logic [LW-1:0]     rem_next;
    logic [SW-1:0]     wr_s, wc_s, nr, nc, fr2, fc2;
    logic              n_in, f_in;
    logic [KIND_W-1:0] fk;
    logic              x_both, x_end;
    logic [3:0]        dmask, bmask, open_after;
    logic [AW-1:0]     scan_addr;
    logic              size_ok_r, size_ok_c;

    wemg_ram #(.WIDTH(KIND_W), .DEPTH(1 << AW)) u_grid (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(g_waddr),
        .i_wdata(g_wdata),
        .i_raddr(g_raddr),
        .o_rdata(g_rdata)
    );

    wemg_ram #(.WIDTH(EW), .DEPTH(LD)) u_list (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(l_waddr),
        .i_wdata(l_wdata),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    always_comb begin
        rows_x    = XW'(r_rows);
        cols_x    = XW'(r_cols);
        fr_x      = XW'(r_fr);
        fc_x      = XW'(r_fc);
        border    = (r_fr == '0) || (r_fc == '0) || (fr_x == rows_x - XW'(1))
                  || (fc_x == cols_x - XW'(1));
        even_int  = !border && !r_fr[0] && !r_fc[0];
        scan_last = (fr_x == rows_x - XW'(1)) && (fc_x == cols_x - XW'(1));
        scan_addr = {r_fr, r_fc};

        size_ok_r = (r_cfg_rows >= DIM_MIN) && r_cfg_rows[0]
                  && ((DIM_W + 1)'(r_cfg_rows) <= (DIM_W + 1)'(MAX_DIM - 1));
        size_ok_c = (r_cfg_cols >= DIM_MIN) && r_cfg_cols[0]
                  && ((DIM_W + 1)'(r_cfg_cols) <= (DIM_W + 1)'(MAX_DIM - 1));

        // Restoring division step, one draw bit per cycle
        trial    = {r_rem, r_dsh[DW-1]};
        rem_next = (trial >= {1'b0, r_len}) ? LW'(trial - {1'b0, r_len}) : LW'(trial);

        // Near and far cells in the drawn direction
        wr_s = SW'(r_walk_r);
        wc_s = SW'(r_walk_c);
        nr   = wr_s;
        nc   = wc_s;
        fr2  = wr_s;
        fc2  = wc_s;
        case (r_draw[1:0])
            DIR_LEFT: begin
                nc  = wc_s - SW'(1);
                fc2 = wc_s - SW'(2);
            end
            DIR_RIGHT: begin
                nc  = wc_s + SW'(1);
                fc2 = wc_s + SW'(2);
            end
            DIR_UP: begin
                nr  = wr_s - SW'(1);
                fr2 = wr_s - SW'(2);
            end
            DIR_DOWN: begin
                nr  = wr_s + SW'(1);
                fr2 = wr_s + SW'(2);
            end
            default: nr = wr_s;
        endcase
        n_in = !nr[SW-1] && !nc[SW-1] && (XW'(nr) < rows_x) && (XW'(nc) < cols_x);
        f_in = !fr2[SW-1] && !fc2[SW-1] && (XW'(fr2) < rows_x) && (XW'(fc2) < cols_x);

        fk         = r_f_in ? g_rdata : KIND_WALL;
        x_both     = (r_nk == KIND_PATH) && (fk == KIND_PATH);
        x_end      = (r_nk == KIND_PATH) && (fk == KIND_WALL);
        dmask      = 4'b0001 << r_dir;
        bmask      = 4'b0001 << (r_dir ^ 2'b01);
        open_after = r_open & ~dmask;

        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = KIND_PATH;
        g_raddr = '0;
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_raddr = '0;
        case (i_cmd.op)
            OP_FILL: begin
                g_we    = 1'b1;
                g_waddr = scan_addr;
                g_wdata = border ? KIND_WALL : KIND_PATH;
                l_we    = even_int;
                l_waddr = LAW'(r_len);
                l_wdata = {r_fr, r_fc};
            end
            OP_PRD1: l_raddr = LAW'(r_rem);
            OP_PRD2: l_raddr = LAW'(r_len - LW'(1));
            OP_PRD3: begin
                l_we    = 1'b1;
                l_waddr = LAW'(r_rem);
                l_wdata = l_rdata;
                g_raddr = r_p;
            end
            OP_PCHK: begin
                g_we    = (g_rdata != KIND_WALL);
                g_waddr = r_p;
                g_wdata = KIND_EXT;
            end
            OP_FSTART: begin
                g_we    = 1'b1;
                g_waddr = {CW'(1), CW'(1)};
                g_wdata = KIND_START;
            end
            OP_FGOAL: begin
                g_we    = 1'b1;
                g_waddr = {CW'(r_rows - 7'd2), CW'(r_cols - 7'd2)};
                g_wdata = KIND_GOAL;
            end
            OP_XNEAR: g_raddr = {nr[CW-1:0], nc[CW-1:0]};
            OP_XFAR:  g_raddr = {r_far_r[CW-1:0], r_far_c[CW-1:0]};
            OP_XDEC: begin
                g_we    = x_both || x_end;
                g_waddr = {r_near_r[CW-1:0], r_near_c[CW-1:0]};
                g_wdata = KIND_EXT;
            end
            OP_XFARW: begin
                g_we    = 1'b1;
                g_waddr = {r_far_r[CW-1:0], r_far_c[CW-1:0]};
                g_wdata = KIND_EXT;
            end
            OP_CM, OP_CME: begin
                g_raddr = scan_addr;
                g_we    = r_cm_v && (g_rdata == KIND_EXT);
                g_waddr = r_cm_addr;
                g_wdata = KIND_WALL;
            end
            OP_RDCELL: g_raddr = {CW'(r_rr), CW'(r_cc)};
            default:   g_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= DIM_RESET;
            r_cfg_cols <= DIM_RESET;
            r_rows     <= '0;
            r_cols     <= '0;
            r_size_err <= 1'b0;
            r_phase    <= PH_IDLE;
            r_len      <= '0;
            r_walk_r   <= '0;
            r_walk_c   <= '0;
            r_open     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROWS) begin
                    r_cfg_rows <= i_cfg_data;
                end else begin
                    r_cfg_cols <= i_cfg_data;
                end
            end
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_func <= i_func;
                    r_draw <= i_draw[DW-1:0];
                    r_rr   <= i_cell_row;
                    r_cc   <= i_cell_col;
                    r_kind <= KIND_PATH;
                end
                OP_BADSIZE: begin
                    r_phase    <= PH_IDLE;
                    r_size_err <= 1'b1;
                end
                OP_FILL_INIT: begin
                    r_rows     <= r_cfg_rows;
                    r_cols     <= r_cfg_cols;
                    r_len      <= '0;
                    r_size_err <= 1'b0;
                    r_fr       <= '0;
                    r_fc       <= '0;
                end
                OP_FILL: begin
                    if (even_int) begin
                        r_len <= r_len + LW'(1);
                    end
                    if (fc_x == cols_x - XW'(1)) begin
                        r_fc <= '0;
                        r_fr <= r_fr + CW'(1);
                    end else begin
                        r_fc <= r_fc + CW'(1);
                    end
                    if (scan_last) begin
                        r_open  <= '0;
                        r_phase <= PH_PICK;
                    end
                end
                OP_DIV_INIT: begin
                    r_rem <= '0;
                    r_dsh <= r_draw;
                    r_cnt <= CNW'(DW);
                end
                OP_DIV: begin
                    r_rem <= rem_next;
                    r_dsh <= r_dsh << 1;
                    r_cnt <= r_cnt - CNW'(1);
                end
                OP_PRD2: r_p   <= l_rdata;
                OP_PRD3: r_len <= r_len - LW'(1);
                OP_PCHK: begin
                    if (g_rdata != KIND_WALL) begin
                        r_walk_r <= r_p[EW-1:CW];
                        r_walk_c <= r_p[CW-1:0];
                        r_open   <= 4'hF;
                        r_phase  <= PH_EXTEND;
                    end
                end
                OP_FGOAL: r_phase <= PH_DONE;
                OP_XNEAR: begin
                    r_dir    <= r_draw[1:0];
                    r_near_r <= nr;
                    r_near_c <= nc;
                    r_far_r  <= fr2;
                    r_far_c  <= fc2;
                    r_n_in   <= n_in;
                    r_f_in   <= f_in;
                end
                OP_XFAR: r_nk <= r_n_in ? g_rdata : KIND_WALL;
                OP_XDEC: begin
                    if (x_both) begin
                        r_walk_r <= r_far_r[CW-1:0];
                        r_walk_c <= r_far_c[CW-1:0];
                        r_open   <= 4'hF & ~bmask;
                    end else if (x_end) begin
                        r_open <= '0;
                    end else begin
                        r_open <= open_after;
                    end
                    r_fr   <= '0;
                    r_fc   <= '0;
                    r_cm_v <= 1'b0;
                end
                OP_CM: begin
                    r_cm_addr <= scan_addr;
                    r_cm_v    <= 1'b1;
                    if (fc_x == cols_x - XW'(1)) begin
                        r_fc <= '0;
                        r_fr <= r_fr + CW'(1);
                    end else begin
                        r_fc <= r_fc + CW'(1);
                    end
                end
                OP_CME:   r_phase <= PH_PICK;
                OP_RDCAP: r_kind  <= g_rdata;
                OP_OUT: begin
                    case (r_phase)
                        PH_DONE:             r_o_status <= STAT_DONE;
                        PH_PICK, PH_EXTEND:  r_o_status <= STAT_GEN;
                        default:             r_o_status <= r_size_err ? STAT_BAD : STAT_IDLE;
                    endcase
                    r_o_kind <= r_kind;
                    r_o_cand <= CAND_W'(r_len);
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_comb begin
        o_stat.func      = r_func;
        o_stat.phase     = r_phase;
        o_stat.size_ok   = size_ok_r && size_ok_c;
        o_stat.rd_ok     = (r_phase != PH_IDLE) && (XW'(r_rr) < rows_x) && (XW'(r_cc) < cols_x);
        o_stat.dir_open  = r_open[r_draw[1:0]];
        o_stat.div_last  = (r_cnt == CNW'(1));
        o_stat.scan_last = scan_last;
        o_stat.p_wall    = (g_rdata == KIND_WALL);
        o_stat.len_zero  = (r_len == '0);
        o_stat.x_both    = x_both;
        o_stat.x_close   = x_end || (!x_both && open_after == 4'h0);
    end

    assign o_status          = r_o_status;
    assign o_cell_kind       = r_o_kind;
    assign o_candidates_left = r_o_cand;
endmodule
